@@ rtl/adw_pkg.sv @@
// Package for the Adagrad dual-averaging weight update block.
// Holds widths, register indexes and a shared payload type; no dependencies.
`default_nettype none
package adw_pkg;
    localparam int CFG_W = 31;
    localparam int VAL_W = 32;
    localparam int SQ_W  = 48;
    localparam int DEN_W = 62;
    localparam int NUM_W = 63;
    localparam int IDX_W = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_LEARN_RATE = 2'd0,
        REG_L1         = 2'd1,
        REG_L2         = 2'd2,
        REG_STEP       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [VAL_W-1:0] weight;
        logic [VAL_W-1:0] accum;
        logic [SQ_W-1:0]  sq_accum;
        logic             zero_divisor;
        logic             saturated;
    } result_t;
endpackage
`default_nettype wire

@@ rtl/adw_sqrt.sv @@
// Pipelined floor square root, one result bit per stage, stall aware.
// Depends on nothing; carries an opaque sideband alongside the root.
`default_nettype none
module adw_sqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [IN_W-1:0]     in_rad,
    input  wire logic [SIDE_W-1:0]   in_side,
    output logic                     out_valid,
    output logic [IN_W/2-1:0]        out_root,
    output logic [SIDE_W-1:0]        out_side
);
    localparam int N = IN_W / 2;

    logic [N:0]        vld_reg;
    logic [IN_W-1:0]   rad_reg  [N+1];
    logic [N+1:0]      rem_reg  [N+1];
    logic [N-1:0]      root_reg [N+1];
    logic [SIDE_W-1:0] side_reg [N+1];

    always_comb begin
        rad_reg[0]  = in_rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [N+1:0] rem_sh;
        logic [N+1:0] trial;
        always_comb begin
            rem_sh = {rem_reg[i][N-1:0], rad_reg[i][IN_W-1 -: 2]};
            trial  = {root_reg[i], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                rad_reg[i+1]  <= {rad_reg[i][IN_W-3:0], 2'b00};
                side_reg[i+1] <= side_reg[i];
                if (rem_sh >= trial) begin
                    rem_reg[i+1]  <= rem_sh - trial;
                    root_reg[i+1] <= {root_reg[i][N-2:0], 1'b1};
                end else begin
                    rem_reg[i+1]  <= rem_sh;
                    root_reg[i+1] <= {root_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];
endmodule
`default_nettype wire

@@ rtl/adw_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, stall aware.
// Depends on nothing; carries an opaque sideband alongside the quotient.
`default_nettype none
module adw_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 62,
    parameter int SIDE_W = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [NUM_W-1:0]    in_num,
    input  wire logic [DEN_W-1:0]    in_den,
    input  wire logic [SIDE_W-1:0]   in_side,
    output logic                     out_valid,
    output logic [NUM_W-1:0]         out_quo,
    output logic [SIDE_W-1:0]        out_side
);
    logic [NUM_W:0]    vld_reg;
    logic [NUM_W-1:0]  num_reg  [NUM_W+1];
    logic [DEN_W:0]    rem_reg  [NUM_W+1];
    logic [DEN_W-1:0]  den_reg  [NUM_W+1];
    logic [SIDE_W-1:0] side_reg [NUM_W+1];

    always_comb begin
        vld_reg[0]  = in_valid;
        num_reg[0]  = in_num;
        rem_reg[0]  = '0;
        den_reg[0]  = in_den;
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W+1:0] rem_sh;
        always_comb rem_sh = {rem_reg[i], num_reg[i][NUM_W-1]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (rem_sh >= {2'b00, den_reg[i]}) begin
                    rem_reg[i+1] <= (DEN_W+1)'(rem_sh - {2'b00, den_reg[i]});
                    num_reg[i+1] <= {num_reg[i][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= rem_sh[DEN_W:0];
                    num_reg[i+1] <= {num_reg[i][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = num_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];
endmodule
`default_nettype wire

@@ rtl/adagrad_da_weight_update.sv @@
// Top level of the Adagrad dual-averaging weight update pipeline.
// Depends on adw_pkg, adw_sqrt and adw_div.
//
// channel   dir  handshake             payload
// s_axis    in   s_tvalid / s_tready   grad_in, accum_in, sq_accum_in
// m_axis    out  m_tvalid / m_tready   weight_out, accum_out, sq_accum_out, flags
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transfer per cycle while the skid is empty; the path runs through 3 front
// stages, 32 square root stages, 1 denominator stage, 63 divider stages and the output register.
// Synchronous active-low reset clears all valid bits and the config registers.
// While m_tready is low the pipeline keeps moving until a result meets the full
// output register; that result parks in a one-entry skid, which freezes the
// pipeline and drops s_tready until the output drains.
`default_nettype none
module adagrad_da_weight_update #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,   // grad_in[31:0], accum_in[63:32], sq_accum_in[111:64]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // weight_out[31:0], accum_out[63:32], sq_accum_out[111:64]
    output logic [1:0]        m_tuser,   // zero_divisor[0], saturated[1]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    localparam int CW = adw_pkg::CFG_W;
    localparam int VW = adw_pkg::VAL_W;
    localparam int SW = adw_pkg::SQ_W;
    localparam int DW = adw_pkg::DEN_W;
    localparam int NW = adw_pkg::NUM_W;
    localparam int RAD_W = ((SW + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam logic [DW-1:0] DEN_MAX = {DW{1'b1}};

    logic [CW-1:0] lr_reg, l1_reg, l2_reg, step_reg;

    assign cfg_ready = aresetn;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= '0; l1_reg <= '0; l2_reg <= '0; step_reg <= '0;
        end else if (cfg_valid) begin
            unique case (adw_pkg::reg_idx_t'(cfg_index))
                adw_pkg::REG_LEARN_RATE: lr_reg   <= cfg_data[CW-1:0];
                adw_pkg::REG_L1:         l1_reg   <= cfg_data[CW-1:0];
                adw_pkg::REG_L2:         l2_reg   <= cfg_data[CW-1:0];
                adw_pkg::REG_STEP:       step_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // per-item constants (the user must keep config static while items flow; the block does not enforce it)
    logic [2*CW-1:0] shrink_reg, l2s_reg;
    always_ff @(posedge aclk) begin
        shrink_reg <= l1_reg * step_reg;
        l2s_reg    <= l2_reg * step_reg;
    end
    // l2*step*lr >> FRAC_BITS in a 31x31 and a 32x31 partial product
    logic [2*CW-1:0] hi_reg;
    logic [2*CW:0]   lo_reg;
    logic [DW-1:0] l2t_reg;
    logic          l2t_sat_reg;
    logic [2*CW+32-FRAC_BITS:0] l2t_sum;
    always_ff @(posedge aclk) begin
        hi_reg <= {{(CW-30){1'b0}}, l2s_reg[61:32]} * lr_reg;
        lo_reg <= l2s_reg[31:0] * lr_reg[CW-1:0];
    end
    always_comb l2t_sum = {hi_reg, {(32-FRAC_BITS){1'b0}}} + (2*CW+33-FRAC_BITS)'(lo_reg >> FRAC_BITS);
    always_ff @(posedge aclk) begin
        l2t_sat_reg <= l2t_sum > (2*CW+33-FRAC_BITS)'(DEN_MAX);
        l2t_reg     <= (l2t_sum > (2*CW+33-FRAC_BITS)'(DEN_MAX)) ? DEN_MAX : l2t_sum[DW-1:0];
    end

    logic en, out_full;
    logic [2:0] vld_reg;

    // stage 1: accumulate, square
    logic signed [VW-1:0] g_s, a_s;
    logic [SW-1:0] sq_in;
    logic signed [VW:0] acc_w;
    logic [VW-1:0] gmag;
    always_comb begin
        g_s   = s_tdata[31:0];
        a_s   = s_tdata[63:32];
        sq_in = s_tdata[111:64];
        acc_w = {g_s[VW-1], g_s} + {a_s[VW-1], a_s};
        gmag  = g_s[VW-1] ? VW'(-g_s) : g_s;
    end
    logic signed [VW-1:0] acc1_reg;
    logic sat1_reg;
    logic [2*VW-1:0] g2_reg;
    logic [SW-1:0] sq1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (acc_w > 33'sh07FFFFFFF) begin
                acc1_reg <= 32'sh7FFFFFFF; sat1_reg <= 1'b1;
            end else if (acc_w < -33'sh080000000) begin
                acc1_reg <= 32'sh80000000; sat1_reg <= 1'b1;
            end else begin
                acc1_reg <= acc_w[VW-1:0]; sat1_reg <= 1'b0;
            end
            g2_reg  <= gmag * gmag;
            sq1_reg <= sq_in;
        end
    end

    // stage 2: squared accumulator add, shrink
    logic [2*VW-FRAC_BITS-1:0] g2s;
    logic [2*VW-FRAC_BITS:0] sqsum;
    logic [VW-1:0] amag;
    always_comb begin
        g2s   = g2_reg[2*VW-1:FRAC_BITS];
        sqsum = (2*VW-FRAC_BITS+1)'(g2s) + (2*VW-FRAC_BITS+1)'(sq1_reg);
        amag  = acc1_reg[VW-1] ? VW'(-acc1_reg) : acc1_reg;
    end
    logic signed [VW-1:0] acc2_reg;
    logic sat2_reg, tneg2_reg;
    logic [SW-1:0] sq2_reg;
    logic [VW-1:0] tmag2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            acc2_reg  <= acc1_reg;
            tneg2_reg <= acc1_reg[VW-1];
            if (sqsum > (2*VW-FRAC_BITS+1)'({SW{1'b1}})) begin
                sq2_reg <= {SW{1'b1}}; sat2_reg <= 1'b1;
            end else begin
                sq2_reg <= sqsum[SW-1:0]; sat2_reg <= sat1_reg;
            end
            if (l1_reg == '0) tmag2_reg <= amag;
            else if ((2*CW)'(amag) > shrink_reg) tmag2_reg <= VW'((2*CW)'(amag) - shrink_reg);
            else tmag2_reg <= '0;
        end
    end

    // stage 3: numerator
    localparam int SIDE1 = VW + SW + 2 + NW;
    logic [NW-1:0] num3_reg;
    logic signed [VW-1:0] acc3_reg;
    logic sat3_reg, tneg3_reg;
    logic [SW-1:0] sq3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            num3_reg  <= NW'(lr_reg * tmag2_reg);
            acc3_reg  <= acc2_reg;
            sat3_reg  <= sat2_reg;
            tneg3_reg <= tneg2_reg;
            sq3_reg   <= sq2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[1:0], s_tvalid};
    end

    logic sq_v;
    logic [ROOT_W-1:0] root;
    logic [SIDE1-1:0] side_q;
    adw_sqrt #(.IN_W(RAD_W), .SIDE_W(SIDE1)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vld_reg[2]),
        .in_rad(RAD_W'({sq3_reg, {FRAC_BITS{1'b0}}})),
        .in_side({num3_reg, tneg3_reg, sat3_reg, sq3_reg, acc3_reg}),
        .out_valid(sq_v), .out_root(root), .out_side(side_q)
    );

    // denominator
    logic [DW:0] den_sum;
    logic [DW-1:0] den4_reg;
    logic [SIDE1-1:0] side4_reg;
    logic den_sat4_reg;
    always_comb den_sum = (DW+1)'(l2t_reg) + (DW+1)'(root);
    always_ff @(posedge aclk) begin
        if (en) begin
            den4_reg     <= den_sum[DW] ? DEN_MAX : den_sum[DW-1:0];
            den_sat4_reg <= den_sum[DW] | l2t_sat_reg;
            side4_reg    <= side_q;
        end
    end
    logic v4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= sq_v;
    end

    localparam int SIDE2 = VW + SW + 3;
    logic dv;
    logic [NW-1:0] quo;
    logic [SIDE2-1:0] side_d;
    logic [NW-1:0] num4;
    logic tneg4, sat4;
    assign num4  = side4_reg[SIDE1-1 -: NW];
    assign tneg4 = side4_reg[VW+SW+1];
    assign sat4  = side4_reg[VW+SW] | den_sat4_reg;
    adw_div #(.NUM_W(NW), .DEN_W(DW), .SIDE_W(SIDE2)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v4_reg),
        .in_num(num4), .in_den(den4_reg),
        .in_side({den4_reg == '0, tneg4, sat4, side4_reg[VW+SW-1:0]}),
        .out_valid(dv), .out_quo(quo), .out_side(side_d)
    );

    // final: clamp and sign
    adw_pkg::result_t res;
    logic zd, tn;
    always_comb begin
        zd = side_d[SIDE2-1];
        tn = side_d[SIDE2-2];
        res.accum        = side_d[VW-1:0];
        res.sq_accum     = side_d[VW+SW-1:VW];
        res.saturated    = side_d[VW+SW];
        res.zero_divisor = zd;
        if (zd) begin
            res.weight = '0;
        end else if (!tn) begin
            if (quo > NW'(33'h080000000)) begin
                res.weight = 32'h80000000; res.saturated = 1'b1;
            end else begin
                res.weight = VW'(-quo[VW-1:0]);
            end
        end else if (quo > NW'(32'h7FFFFFFF)) begin
            res.weight = 32'h7FFFFFFF; res.saturated = 1'b1;
        end else begin
            res.weight = quo[VW-1:0];
        end
    end

    // output register with skid
    adw_pkg::result_t out_reg, skid_reg;
    logic out_v_reg, skid_v_reg;
    assign en       = !skid_v_reg;
    assign out_full = out_v_reg && !m_tready;
    assign s_tready = en && aresetn;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (!out_full) begin
                out_v_reg  <= skid_v_reg | (en & dv);
                skid_v_reg <= 1'b0;
            end else if (en & dv) begin
                skid_v_reg <= 1'b1;
            end
        end
        if (!out_full) out_reg <= skid_v_reg ? skid_reg : res;
        else if (en & dv) skid_reg <= res;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.sq_accum, out_reg.accum, out_reg.weight};
    assign m_tuser  = {out_reg.saturated, out_reg.zero_divisor};
endmodule
`default_nettype wire

@@ rtl/adw_checker.sv @@
// Port-level checker for the weight update block, bound to its top level.
// Depends on the top level's ports only.
`default_nettype none
module adw_port_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata,
    input wire logic [1:0]   m_tuser,
    input wire logic         cfg_ready
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");
    a_zero_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'h0)
        else $error("zero divisor with nonzero weight");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("config port not ready");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind adagrad_da_weight_update adw_port_checker u_adw_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_ready(cfg_ready)
);
`default_nettype wire
